>>> sv/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types, constants and the node id table of the packet sequence tracker.
// ----------------------------------------------------------------------------
package pst_pkg;

	// Defaults for the top-level parameters.
	localparam int DEF_PAGES    = 4;
	localparam int DEF_NODES    = 18;
	localparam int DEF_SEQ_BITS = 16;

	// Fixed field widths of the beats.
	localparam int SEQ_W      = 16;
	localparam int NODE_ID_W  = 8;
	localparam int NODE_IDX_W = 5;
	localparam int STATUS_W   = 2;
	localparam int PAGE_OUT_W = 2;

	// The seen bitmap is stored in rows of 256 bits.
	localparam int ROW_BITS  = 256;
	localparam int ROW_IDX_W = 8;

	// One statistics word holds first, last and maximum.
	localparam int STAT_W = 3 * SEQ_W;

	// Depth of the queue between front and back.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	// Known node ids, in match order.
	localparam int ID_COUNT = 18;
	localparam logic [NODE_ID_W-1:0] ID_TABLE [ID_COUNT] = '{
		8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12,
		8'd17, 8'd18, 8'd243, 8'd244, 8'd241, 8'd242
	};

	typedef enum logic [STATUS_W-1:0] {
		STS_NEW     = 2'd0,
		STS_DUP     = 2'd1,
		STS_UNKNOWN = 2'd2,
		STS_CLEARED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_UPDATE
	} back_state_t;

	// A classified item as it travels from front to back.
	typedef struct packed {
		logic                  func;
		logic                  hit;
		logic [NODE_IDX_W-1:0] node;
		logic [SEQ_W-1:0]      seq;
	} cmd_t;

endpackage

>>> sv/pst_ram.sv
// ----------------------------------------------------------------------------
// pst_ram
// Generic single-port RAM with a registered read port.
// ----------------------------------------------------------------------------
module pst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

>>> sv/pst_front.sv
// ----------------------------------------------------------------------------
// pst_front
// Accepts input beats, looks up the node id and masks the sequence number.
// ----------------------------------------------------------------------------
module pst_front
	import pst_pkg::*;
#(
	parameter int NODES    = DEF_NODES,
	parameter int SEQ_BITS = DEF_SEQ_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 func,
	input  logic [NODE_ID_W-1:0] node_id,
	input  logic [SEQ_W-1:0]     seq_num,
	output logic                 push,
	output cmd_t                 push_cmd,
	input  logic                 q_full
);

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t cmd_c;
	logic accept;

	// The first matching table entry below NODES gives the node index.
	always_comb begin
		cmd_c      = '0;
		cmd_c.func = func;
		cmd_c.seq  = SEQ_W'(seq_num[SEQ_BITS-1:0]);
		for (int i = 0; i < ID_COUNT; i++) begin
			if (i < NODES && ID_TABLE[i] == node_id && !cmd_c.hit) begin
				cmd_c.hit  = 1'b1;
				cmd_c.node = NODE_IDX_W'(i);
			end
		end
	end

	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !q_full;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_c;
		end
	end

endmodule

>>> sv/pst_queue.sv
// ----------------------------------------------------------------------------
// pst_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module pst_queue
	import pst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic not_empty
);

	cmd_t               entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign full      = (count_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> sv/pst_back.sv
// ----------------------------------------------------------------------------
// pst_back
// Executes queued items: clearing pass, seen bitmap and statistics updates.
// ----------------------------------------------------------------------------
module pst_back
	import pst_pkg::*;
#(
	parameter int PAGES    = DEF_PAGES,
	parameter int NODES    = DEF_NODES,
	parameter int SEQ_BITS = DEF_SEQ_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  cmd_t                  q_cmd,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [PAGE_OUT_W-1:0] page_used,
	output logic [SEQ_W-1:0]      first_seq,
	output logic [SEQ_W-1:0]      last_seq,
	output logic [SEQ_W-1:0]      max_seq
);

	localparam int SLOTS  = NODES * PAGES;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ROWS   = SLOTS << (SEQ_BITS - ROW_IDX_W);
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int BIT_W  = SLOT_W + SEQ_BITS;
	localparam int MUL_W  = SLOT_W + 6;

	back_state_t state_q, state_d;

	logic [ROW_W-1:0]     clr_cnt_q;
	logic [PAGE_W-1:0]    node_page_q [NODES];
	cmd_t                 cmd_q;
	logic [PAGE_W-1:0]    page_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [ROW_W-1:0]     row_q;
	logic [ROW_IDX_W-1:0] bit_q;

	// Lookup of the queued item.
	logic [PAGE_W-1:0] cur_page;
	logic [MUL_W-1:0]  slot_wide;
	logic [SLOT_W-1:0] cur_slot;
	logic [BIT_W-1:0]  bit_idx;
	logic [ROW_W-1:0]  cur_row;

	// Update arithmetic of the item in flight.
	logic [SEQ_W-1:0] seq_x;
	logic [SEQ_W-1:0] rd_first, rd_last, rd_max;
	logic [SEQ_W-1:0] nw_first, nw_max;
	logic             was_seen;
	logic             can_adv;

	// RAM ports.
	logic                seen_we, seen_re;
	logic [ROW_W-1:0]    seen_addr;
	logic [ROW_BITS-1:0] seen_wdata, seen_rdata;
	logic                stat_we, stat_re;
	logic [SLOT_W-1:0]   stat_addr;
	logic [STAT_W-1:0]   stat_wdata, stat_rdata;

	// Controls.
	logic    out_free;
	logic    cap;
	logic    pg_clear;
	logic    pg_adv;
	logic    out_load;
	status_t out_status;
	logic    clr_last;

	assign out_free = !out_valid || !out_stall;
	assign clr_last = (clr_cnt_q == ROW_W'(ROWS - 1));

	always_comb begin
		cur_page  = node_page_q[q_cmd.node[NODE_W-1:0]];
		slot_wide = MUL_W'(q_cmd.node) * MUL_W'(PAGES) + MUL_W'(cur_page);
		cur_slot  = slot_wide[SLOT_W-1:0];
		bit_idx   = {cur_slot, q_cmd.seq[SEQ_BITS-1:0]};
		cur_row   = bit_idx[ROW_IDX_W +: ROW_W];
	end

	always_comb begin
		seq_x    = cmd_q.seq;
		rd_first = stat_rdata[2*SEQ_W +: SEQ_W];
		rd_last  = stat_rdata[SEQ_W +: SEQ_W];
		rd_max   = stat_rdata[0 +: SEQ_W];
		nw_first = (rd_first == '0) ? seq_x : rd_first;
		nw_max   = (seq_x > rd_max || rd_max == '0) ? seq_x : rd_max;
		was_seen = seen_rdata[bit_q];
		can_adv  = (&cmd_q.seq[SEQ_BITS-1:0]) && (page_q != PAGE_W'(PAGES - 1));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR: begin
				if (clr_last) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (q_valid && out_free) begin
					if (q_cmd.func) begin
						state_d = BK_CLEAR;
					end else if (q_cmd.hit) begin
						state_d = BK_UPDATE;
					end
				end
			end
			BK_UPDATE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		pop        = 1'b0;
		cap        = 1'b0;
		pg_clear   = 1'b0;
		pg_adv     = 1'b0;
		out_load   = 1'b0;
		out_status = STS_NEW;
		seen_we    = 1'b0;
		seen_re    = 1'b0;
		seen_addr  = cur_row;
		seen_wdata = '0;
		stat_we    = 1'b0;
		stat_re    = 1'b0;
		stat_addr  = cur_slot;
		stat_wdata = '0;
		case (state_q)
			BK_CLEAR: begin
				seen_we   = 1'b1;
				seen_addr = clr_cnt_q;
				stat_we   = ({1'b0, clr_cnt_q} < (ROW_W + 1)'(SLOTS));
				stat_addr = clr_cnt_q[SLOT_W-1:0];
			end
			BK_IDLE: begin
				if (q_valid && out_free) begin
					pop = 1'b1;
					if (q_cmd.func) begin
						pg_clear   = 1'b1;
						out_load   = 1'b1;
						out_status = STS_CLEARED;
					end else if (!q_cmd.hit) begin
						out_load   = 1'b1;
						out_status = STS_UNKNOWN;
					end else begin
						cap     = 1'b1;
						seen_re = 1'b1;
						stat_re = 1'b1;
					end
				end
			end
			BK_UPDATE: begin
				seen_addr = row_q;
				stat_addr = slot_q;
				if (out_free) begin
					out_load = 1'b1;
					if (was_seen) begin
						out_status = STS_DUP;
					end else begin
						out_status = STS_NEW;
						pg_adv     = can_adv;
						seen_we    = 1'b1;
						seen_wdata = seen_rdata | (ROW_BITS'(1) << bit_q);
						stat_we    = 1'b1;
						stat_wdata = {nw_first, seq_x, nw_max};
					end
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	pst_ram #(
		.WIDTH(ROW_BITS),
		.DEPTH(ROWS)
	) u_seen_ram (
		.clk  (clk),
		.we   (seen_we),
		.re   (seen_re),
		.addr (seen_addr),
		.wdata(seen_wdata),
		.rdata(seen_rdata)
	);

	pst_ram #(
		.WIDTH(STAT_W),
		.DEPTH(SLOTS)
	) u_stat_ram (
		.clk  (clk),
		.we   (stat_we),
		.re   (stat_re),
		.addr (stat_addr),
		.wdata(stat_wdata),
		.rdata(stat_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLEAR;
			clr_cnt_q <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < NODES; i++) begin
				node_page_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (pg_clear) begin
				clr_cnt_q <= '0;
			end else if (state_q == BK_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (pg_clear) begin
				for (int i = 0; i < NODES; i++) begin
					node_page_q[i] <= '0;
				end
			end else if (pg_adv) begin
				node_page_q[cmd_q.node[NODE_W-1:0]] <= page_q + 1'b1;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			cmd_q  <= q_cmd;
			page_q <= cur_page;
			slot_q <= cur_slot;
			row_q  <= cur_row;
			bit_q  <= q_cmd.seq[ROW_IDX_W-1:0];
		end
		if (out_load) begin
			status <= out_status;
			if (state_q == BK_UPDATE) begin
				page_used <= PAGE_OUT_W'(page_q);
				first_seq <= was_seen ? rd_first : nw_first;
				last_seq  <= was_seen ? rd_last : seq_x;
				max_seq   <= was_seen ? rd_max : nw_max;
			end else begin
				page_used <= '0;
				first_seq <= '0;
				last_seq  <= '0;
				max_seq   <= '0;
			end
		end
	end

endmodule

>>> sv/packet_sequence_tracker.sv
// ----------------------------------------------------------------------------
// packet_sequence_tracker
// Per-node packet sequence tracking with paged seen bitmaps and statistics.
// ----------------------------------------------------------------------------
// Input beats carry func, node_id and seq_num on the in_valid / in_stall
// channel; a beat is taken at a clock edge with in_valid high and in_stall low.
// Every input beat yields exactly one result beat on out_valid / out_stall,
// carrying status, page_used and the first, last and maximum numbers.
// A record beat is handled in the back end as a read of the seen bitmap row
// and the statistics word, then a write back of both together with the load
// of the result. The back end takes no new item before it has written back
// the last, as this read-modify-write uses the single-port bitmap memory. On
// its way a record beat passes the front register, the queue, the memory read
// register and the result register. Unknown node ids and clear beats load
// their result from the idle state, with no memory access. After reset, and
// after every clear beat, the back end sweeps the bitmap memory one row per
// cycle, all NODES*PAGES*2^(SEQ_BITS-8) rows (18432 with the default sizes),
// and takes no item from its queue meanwhile. The result of a clear beat is
// presented when that sweep starts and does not wait for the sweep to finish.
// While out_stall is high the result register holds; the front register and
// the two-entry queue keep accepting until they fill, then in_stall rises.
// ----------------------------------------------------------------------------
module packet_sequence_tracker
	import pst_pkg::*;
#(
	parameter int PAGES    = DEF_PAGES,
	parameter int NODES    = DEF_NODES,
	parameter int SEQ_BITS = DEF_SEQ_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  func,
	input  logic [NODE_ID_W-1:0]  node_id,
	input  logic [SEQ_W-1:0]      seq_num,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [PAGE_OUT_W-1:0] page_used,
	output logic [SEQ_W-1:0]      first_seq,
	output logic [SEQ_W-1:0]      last_seq,
	output logic [SEQ_W-1:0]      max_seq
);

	// Classified items travel from the front end into the queue.
	logic push;
	cmd_t push_cmd;
	logic q_full;

	// The back end pops from the queue when it can start an item.
	logic pop;
	cmd_t q_cmd;
	logic q_valid;

	// The front end resolves the node id to a table index and masks the
	// sequence number; page lookup waits for the back end, since earlier
	// packets still in the queue may advance the page.
	pst_front #(
		.NODES   (NODES),
		.SEQ_BITS(SEQ_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func    (func),
		.node_id (node_id),
		.seq_num (seq_num),
		.push    (push),
		.push_cmd(push_cmd),
		.q_full  (q_full)
	);

	pst_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (q_cmd),
		.not_empty(q_valid)
	);

	// The back end owns all tracking state: node pages, the seen bitmap and
	// the statistics memory, plus the result register.
	pst_back #(
		.PAGES   (PAGES),
		.NODES   (NODES),
		.SEQ_BITS(SEQ_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.page_used(page_used),
		.first_seq(first_seq),
		.last_seq (last_seq),
		.max_seq  (max_seq)
	);

endmodule
